// ----- src/perfect_hash_key_lookup_macros.svh -----
// Assertion macros shared by the perfect hash key lookup RTL.
// Requires clk and arst_n in the scope of each use.
`ifndef PERFECT_HASH_KEY_LOOKUP_MACROS_SVH
`define PERFECT_HASH_KEY_LOOKUP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PHKL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PHKL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/phkl_pkg.sv -----
// Shared types, codes and default sizes for the perfect hash key lookup.
// Used by phkl_ctrl, phkl_dp, the top and the testbench; depends on nothing.
package phkl_pkg;

	localparam int DEF_NUM_CLASSES = 8;
	localparam int DEF_MAX_KEY_LEN = 32;
	localparam int DEF_G_SIZE      = 256;
	localparam int DEF_TABLE_SIZE  = 256;
	localparam int SUM_W           = 29;

	typedef enum logic [2:0] {
		REQ_WEIGHT = 3'd0,
		REQ_G      = 3'd1,
		REQ_KEY    = 3'd2,
		REQ_SIZES  = 3'd3,
		REQ_CHAR   = 3'd4
	} req_type_t;

	typedef enum logic [1:0] {
		RES_FOUND = 2'd0,
		RES_LONG  = 2'd1,
		RES_MISS  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MOD_A = 2'd0,
		MOD_B = 2'd1,
		MOD_G = 2'd2
	} mod_sel_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [2:0]  class_id;
		logic [7:0]  slot;
		logic [5:0]  position;
		logic [15:0] weight_a;
		logic [15:0] weight_b;
		logic [7:0]  g_value;
		logic [7:0]  char_code;
		logic [8:0]  size_n;
		logic [8:0]  size_m;
		logic [5:0]  max_len;
	} in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] slot_index;
	} out_t;

	typedef struct packed {
		logic     capture;
		logic     wt_wr;
		logic     g_wr;
		logic     cls_wr;
		logic     key_wr;
		logic     row_ld;
		logic     row_from_idx;
		logic     base_ld;
		logic     name_wr;
		logic     over_set;
		logic     mul;
		logic     acc;
		logic     mod_start;
		mod_sel_t mod_sel;
		logic     u_ld;
		logic     v_ld;
		logic     g_sel_v;
		logic     gu_ld;
		logic     idx_ld;
		logic     walk_clr;
		logic     walk_inc;
		logic     res_ld;
		status_t  res_status;
		logic     clear_name;
	} cmd_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic       cls_ok;
		logic       wt_ok;
		logic       g_ok;
		logic       key_ok;
		logic       char_zero;
		logic       len_full;
		logic       too_long;
		logic       mod_done;
		logic       walk_last;
		logic       mismatch;
		logic       out_free;
	} sts_t;

endpackage

// ----- src/phkl_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module phkl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rd_q <= mem[addr];
	end

	assign rdata = rd_q;

endmodule

// ----- src/phkl_mod.sv -----
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// No dependencies.
module phkl_mod #(
	parameter int DW = 29,
	parameter int SW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [SW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [SW-1:0] rem
);

	localparam int CW = (DW > 1) ? $clog2(DW) : 1;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] num_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] div_q;
	logic [SW:0]   trial;
	logic [SW:0]   diff;
	logic [SW-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, num_q[DW-1]};
		diff    = trial - {1'b0, div_q};
		rem_nxt = (trial >= {1'b0, div_q}) ? diff[SW-1:0] : trial[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= rem_nxt;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ----- src/phkl_ctrl.sv -----
// Sequencer of the perfect hash key lookup: one item at a time.
// Depends on phkl_pkg; drives phkl_dp through cmd_t and reads sts_t.
module phkl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  phkl_pkg::sts_t  sts,
	output phkl_pkg::cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_KWR, S_MUL, S_ACC, S_CHK, S_MODU, S_MODV, S_GU, S_GV,
		S_GSUM, S_MODG, S_KROW, S_KBASE, S_KRD, S_KCMP, S_RES
	} state_t;

	state_t             state_q;
	state_t             state_d;
	phkl_pkg::status_t  res_q;
	phkl_pkg::status_t  res_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.mod_sel    = phkl_pkg::MOD_A;
		cmd.res_status = res_q;
		state_d        = state_q;
		res_d          = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_IDLE;
				unique case (sts.req_type)
					phkl_pkg::REQ_WEIGHT: cmd.wt_wr = sts.wt_ok;
					phkl_pkg::REQ_G:      cmd.g_wr = sts.g_ok;
					phkl_pkg::REQ_SIZES:  cmd.cls_wr = sts.cls_ok;
					phkl_pkg::REQ_KEY: begin
						if (sts.key_ok) begin
							cmd.row_ld = 1'b1;
							state_d    = S_KWR;
						end
					end
					phkl_pkg::REQ_CHAR: begin
						if (sts.char_zero) begin
							if (sts.cls_ok) begin
								state_d = S_CHK;
							end else begin
								res_d   = phkl_pkg::RES_MISS;
								state_d = S_RES;
							end
						end else if (sts.len_full) begin
							cmd.over_set = 1'b1;
						end else begin
							cmd.name_wr = 1'b1;
							if (sts.cls_ok) begin
								state_d = S_MUL;
							end
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_KWR: begin
				cmd.key_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_IDLE;
			end
			S_CHK: begin
				if (sts.too_long) begin
					res_d   = phkl_pkg::RES_LONG;
					state_d = S_RES;
				end else begin
					cmd.mod_start = 1'b1;
					cmd.mod_sel   = phkl_pkg::MOD_A;
					state_d       = S_MODU;
				end
			end
			S_MODU: begin
				if (sts.mod_done) begin
					cmd.u_ld      = 1'b1;
					cmd.mod_start = 1'b1;
					cmd.mod_sel   = phkl_pkg::MOD_B;
					state_d       = S_MODV;
				end
			end
			S_MODV: begin
				if (sts.mod_done) begin
					cmd.v_ld = 1'b1;
					state_d  = S_GU;
				end
			end
			S_GU: begin
				state_d = S_GV;
			end
			S_GV: begin
				cmd.g_sel_v = 1'b1;
				cmd.gu_ld   = 1'b1;
				state_d     = S_GSUM;
			end
			S_GSUM: begin
				cmd.mod_start = 1'b1;
				cmd.mod_sel   = phkl_pkg::MOD_G;
				state_d       = S_MODG;
			end
			S_MODG: begin
				cmd.mod_sel = phkl_pkg::MOD_G;
				if (sts.mod_done) begin
					cmd.idx_ld = 1'b1;
					state_d    = S_KROW;
				end
			end
			S_KROW: begin
				cmd.row_ld       = 1'b1;
				cmd.row_from_idx = 1'b1;
				state_d          = S_KBASE;
			end
			S_KBASE: begin
				cmd.base_ld  = 1'b1;
				cmd.walk_clr = 1'b1;
				state_d      = S_KRD;
			end
			S_KRD: begin
				state_d = S_KCMP;
			end
			S_KCMP: begin
				if (sts.mismatch) begin
					res_d   = phkl_pkg::RES_MISS;
					state_d = S_RES;
				end else if (sts.walk_last) begin
					res_d   = phkl_pkg::RES_FOUND;
					state_d = S_RES;
				end else begin
					cmd.walk_inc = 1'b1;
					state_d      = S_KRD;
				end
			end
			S_RES: begin
				if (sts.out_free) begin
					cmd.res_ld     = 1'b1;
					cmd.clear_name = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= phkl_pkg::RES_FOUND;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

// ----- src/phkl_dp.sv -----
// Datapath of the perfect hash key lookup: stores, sums, remainder unit, result register.
// Depends on phkl_pkg, phkl_ram, phkl_mod and the assertion macros header.
`include "perfect_hash_key_lookup_macros.svh"

module phkl_dp #(
	parameter int NUM_CLASSES = phkl_pkg::DEF_NUM_CLASSES,
	parameter int MAX_KEY_LEN = phkl_pkg::DEF_MAX_KEY_LEN,
	parameter int G_SIZE      = phkl_pkg::DEF_G_SIZE,
	parameter int TABLE_SIZE  = phkl_pkg::DEF_TABLE_SIZE
) (
	input  logic           clk,
	input  logic           arst_n,
	input  phkl_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output phkl_pkg::out_t out_data,
	input  phkl_pkg::cmd_t cmd,
	output phkl_pkg::sts_t sts
);

	localparam int SUMW    = phkl_pkg::SUM_W;
	localparam int CLW     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int LENW    = $clog2(MAX_KEY_LEN + 1);
	localparam int NIW     = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
	localparam int WD      = NUM_CLASSES * MAX_KEY_LEN;
	localparam int WAW     = (WD > 1) ? $clog2(WD) : 1;
	localparam int GD      = NUM_CLASSES * G_SIZE;
	localparam int GAW     = (GD > 1) ? $clog2(GD) : 1;
	localparam int GIW     = $clog2(G_SIZE);
	localparam int TIW     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int SW      = $clog2(((G_SIZE > TABLE_SIZE) ? G_SIZE : TABLE_SIZE) + 1);
	localparam int KEY_ROW = MAX_KEY_LEN + 1;
	localparam int RD      = NUM_CLASSES * TABLE_SIZE;
	localparam int RW      = (RD > 1) ? $clog2(RD) : 1;
	localparam int KD      = RD * KEY_ROW;
	localparam int KAW     = (KD > 1) ? $clog2(KD) : 1;
	localparam int CDW     = 2 * SW + LENW;

	phkl_pkg::in_t  in_q;
	phkl_pkg::out_t out_q;
	logic           out_valid_q;

	logic [SUMW-1:0] sum_a_q;
	logic [SUMW-1:0] sum_b_q;
	logic [LENW-1:0] len_q;
	logic            over_q;
	logic [23:0]     prod_a_q;
	logic [23:0]     prod_b_q;
	logic [GIW-1:0]  u_q;
	logic [GIW-1:0]  v_q;
	logic [7:0]      gu_q;
	logic [TIW-1:0]  idx_q;
	logic [RW-1:0]   row_q;
	logic [KAW-1:0]  base_q;
	logic [LENW-1:0] walk_q;

	logic [CLW-1:0]  cls_idx;
	logic            cls_ok;
	logic [WAW-1:0]  wt_addr;
	logic [31:0]     wt_rd;
	logic [GAW-1:0]  g_addr;
	logic [7:0]      g_rd;
	logic [CDW-1:0]  cls_wdata;
	logic [CDW-1:0]  cls_rd;
	logic [SW-1:0]   cls_n;
	logic [SW-1:0]   cls_m;
	logic [LENW-1:0] cls_ml;
	logic [NIW-1:0]  name_addr;
	logic [7:0]      name_rd;
	logic [KAW-1:0]  key_addr;
	logic [7:0]      key_rd;
	logic [RW-1:0]   row_d;
	logic [SUMW-1:0] mod_dividend;
	logic [SW-1:0]   mod_divisor;
	logic            mod_busy;
	logic            mod_done;
	logic [SW-1:0]   mod_rem;
	logic [31:0]     sn;
	logic [31:0]     sm;
	logic [31:0]     sl;
	logic [SW-1:0]   n_clamp;
	logic [SW-1:0]   m_clamp;
	logic [LENW-1:0] ml_clamp;
	logic            walk_last;

	assign cls_idx = CLW'(in_q.class_id);
	assign cls_ok  = 32'(in_q.class_id) < NUM_CLASSES;

	always_comb begin
		sn       = 32'(in_data.size_n);
		sm       = 32'(in_data.size_m);
		sl       = 32'(in_data.max_len);
		sn       = 32'(in_q.size_n);
		sm       = 32'(in_q.size_m);
		sl       = 32'(in_q.max_len);
		n_clamp  = (sn == 32'd0) ? SW'(1) : ((sn > G_SIZE) ? SW'(G_SIZE) : SW'(sn));
		m_clamp  = (sm == 32'd0) ? SW'(1) : ((sm > TABLE_SIZE) ? SW'(TABLE_SIZE) : SW'(sm));
		ml_clamp = (sl > MAX_KEY_LEN) ? LENW'(MAX_KEY_LEN) : LENW'(sl);
	end

	assign cls_wdata = {n_clamp, m_clamp, ml_clamp};
	assign cls_n     = cls_rd[CDW-1 -: SW];
	assign cls_m     = cls_rd[LENW +: SW];
	assign cls_ml    = cls_rd[LENW-1:0];

	assign wt_addr = WAW'(32'(cls_idx) * MAX_KEY_LEN
		+ (cmd.wt_wr ? 32'(in_q.position) : 32'(len_q)));
	assign g_addr = GAW'(32'(cls_idx) * G_SIZE
		+ (cmd.g_wr ? 32'(in_q.slot) : (cmd.g_sel_v ? 32'(v_q) : 32'(u_q))));
	assign name_addr = cmd.name_wr ? NIW'(len_q) : NIW'(walk_q);
	assign key_addr = cmd.key_wr ? KAW'(32'(row_q) * KEY_ROW + 32'(in_q.position))
		: KAW'(32'(base_q) + 32'(walk_q));
	assign row_d = RW'(32'(cls_idx) * TABLE_SIZE
		+ (cmd.row_from_idx ? 32'(idx_q) : 32'(in_q.slot)));

	always_comb begin
		mod_dividend = sum_a_q;
		mod_divisor  = cls_n;
		unique case (cmd.mod_sel)
			phkl_pkg::MOD_A: mod_dividend = sum_a_q;
			phkl_pkg::MOD_B: mod_dividend = sum_b_q;
			phkl_pkg::MOD_G: begin
				mod_dividend = SUMW'(gu_q) + SUMW'(g_rd);
				mod_divisor  = cls_m;
			end
			default: mod_dividend = sum_a_q;
		endcase
	end

	phkl_ram #(.WIDTH(32), .DEPTH(WD)) u_wt_ram (
		.clk(clk), .we(cmd.wt_wr), .addr(wt_addr),
		.wdata({in_q.weight_a, in_q.weight_b}), .rdata(wt_rd)
	);

	phkl_ram #(.WIDTH(8), .DEPTH(GD)) u_g_ram (
		.clk(clk), .we(cmd.g_wr), .addr(g_addr), .wdata(in_q.g_value), .rdata(g_rd)
	);

	phkl_ram #(.WIDTH(CDW), .DEPTH(NUM_CLASSES)) u_cls_ram (
		.clk(clk), .we(cmd.cls_wr), .addr(cls_idx), .wdata(cls_wdata), .rdata(cls_rd)
	);

	phkl_ram #(.WIDTH(8), .DEPTH(MAX_KEY_LEN)) u_name_ram (
		.clk(clk), .we(cmd.name_wr), .addr(name_addr), .wdata(in_q.char_code),
		.rdata(name_rd)
	);

	phkl_ram #(.WIDTH(8), .DEPTH(KD)) u_key_ram (
		.clk(clk), .we(cmd.key_wr), .addr(key_addr), .wdata(in_q.char_code),
		.rdata(key_rd)
	);

	phkl_mod #(.DW(SUMW), .SW(SW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(cmd.mod_start), .dividend(mod_dividend),
		.divisor(mod_divisor), .busy(mod_busy), .done(mod_done), .rem(mod_rem)
	);

	assign walk_last = (walk_q == len_q);

	always_comb begin
		sts.req_type  = in_q.req_type;
		sts.cls_ok    = cls_ok;
		sts.wt_ok     = cls_ok && (32'(in_q.position) < MAX_KEY_LEN);
		sts.g_ok      = cls_ok && (32'(in_q.slot) < G_SIZE);
		sts.key_ok    = cls_ok && (32'(in_q.slot) < TABLE_SIZE)
			&& (32'(in_q.position) <= MAX_KEY_LEN);
		sts.char_zero = (in_q.char_code == 8'd0);
		sts.len_full  = (32'(len_q) >= MAX_KEY_LEN);
		sts.too_long  = over_q || (len_q > cls_ml);
		sts.mod_done  = mod_done;
		sts.walk_last = walk_last;
		sts.mismatch  = (key_rd != (walk_last ? 8'd0 : name_rd));
		sts.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q     <= '0;
			sum_b_q     <= '0;
			len_q       <= '0;
			over_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_name) begin
				sum_a_q <= '0;
				sum_b_q <= '0;
				len_q   <= '0;
				over_q  <= 1'b0;
			end else begin
				if (cmd.acc) begin
					sum_a_q <= sum_a_q + SUMW'(prod_a_q);
					sum_b_q <= sum_b_q + SUMW'(prod_b_q);
				end
				if (cmd.name_wr) begin
					len_q <= len_q + LENW'(1);
				end
				if (cmd.over_set) begin
					over_q <= 1'b1;
				end
			end
			if (cmd.res_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= in_data;
		end
		if (cmd.mul) begin
			prod_a_q <= wt_rd[31:16] * in_q.char_code;
			prod_b_q <= wt_rd[15:0] * in_q.char_code;
		end
		if (cmd.u_ld) begin
			u_q <= GIW'(mod_rem);
		end
		if (cmd.v_ld) begin
			v_q <= GIW'(mod_rem);
		end
		if (cmd.gu_ld) begin
			gu_q <= g_rd;
		end
		if (cmd.idx_ld) begin
			idx_q <= TIW'(mod_rem);
		end
		if (cmd.row_ld) begin
			row_q <= row_d;
		end
		if (cmd.base_ld) begin
			base_q <= KAW'(32'(row_q) * KEY_ROW);
		end
		if (cmd.walk_clr) begin
			walk_q <= '0;
		end else if (cmd.walk_inc) begin
			walk_q <= walk_q + LENW'(1);
		end
		if (cmd.res_ld) begin
			out_q.status     <= cmd.res_status;
			out_q.slot_index <= (cmd.res_status == phkl_pkg::RES_FOUND) ? 8'(idx_q) : 8'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`PHKL_ASSERT_IMP(a_mod_idle, cmd.mod_start, !mod_busy, "Remainder unit started while busy.")
	`PHKL_ASSERT_IMP(a_res_free, cmd.res_ld, !out_valid_q || out_ready, "Result overwritten.")
	`PHKL_ASSERT_IMP(a_len_max, cmd.name_wr, 32'(len_q) < MAX_KEY_LEN, "Name store overrun.")
	`PHKL_ASSERT_NXT(a_clear, cmd.res_ld, len_q == '0 && !over_q && sum_a_q == '0, "Name not cleared.")

endmodule

// ----- src/perfect_hash_key_lookup.sv -----
// Perfect hash key lookup, one table set per class, loaded and queried by input beats.
// A beat is captured, then dispatched; a key character load adds a write state, and
// a name character a multiply and an accumulate state when its class is in range. A
// terminator of an in-range name that is not too long runs three passes of the shared
// bit-serial remainder unit (two g indexes and the slot), then a key walk of a read and
// a compare state per character through the single port of the key memory. Results
// leave through an output register; a new one waits for the last. Stores are not cleared.
module perfect_hash_key_lookup #(
	parameter int NUM_CLASSES = phkl_pkg::DEF_NUM_CLASSES,
	parameter int MAX_KEY_LEN = phkl_pkg::DEF_MAX_KEY_LEN,
	parameter int G_SIZE      = phkl_pkg::DEF_G_SIZE,
	parameter int TABLE_SIZE  = phkl_pkg::DEF_TABLE_SIZE
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  phkl_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output phkl_pkg::out_t out_data
);

	phkl_pkg::cmd_t cmd;
	phkl_pkg::sts_t sts;

	phkl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sts(sts), .cmd(cmd)
	);

	phkl_dp #(
		.NUM_CLASSES(NUM_CLASSES), .MAX_KEY_LEN(MAX_KEY_LEN),
		.G_SIZE(G_SIZE), .TABLE_SIZE(TABLE_SIZE)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .out_valid(out_valid),
		.out_ready(out_ready), .out_data(out_data), .cmd(cmd), .sts(sts)
	);

endmodule

// ----- dv/perfect_hash_key_lookup_tb.sv -----
// Self-checking testbench for the perfect hash key lookup: loads class tables, streams names
// and compares each lookup result with a behavioral predictor held in a scoreboard class.
// Depends on phkl_pkg and the perfect_hash_key_lookup RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import phkl_pkg::*;

	localparam int NCLS = DEF_NUM_CLASSES;
	localparam int MAXL = DEF_MAX_KEY_LEN;
	localparam int GSZ  = DEF_G_SIZE;
	localparam int TSZ  = DEF_TABLE_SIZE;
	localparam int ROW  = MAXL + 1;

	class lookup_board;
		logic [15:0] wt_a [NCLS*MAXL];
		logic [15:0] wt_b [NCLS*MAXL];
		logic [7:0]  g_tab [NCLS*GSZ];
		logic [7:0]  keys [NCLS*TSZ*ROW];
		int          n_of [NCLS];
		int          m_of [NCLS];
		int          ml_of [NCLS];
		logic [SUM_W-1:0] acc_a, acc_b;
		logic [7:0]  name [MAXL];
		int          name_len;
		bit          overlong;
		out_t        pending [$];
		int          errors;

		function new();
			errors = 0;
			foreach (wt_a[i]) begin
				wt_a[i] = 0;
				wt_b[i] = 0;
			end
			foreach (g_tab[i]) g_tab[i] = 0;
			foreach (keys[i]) keys[i] = 0;
			foreach (n_of[i]) begin
				n_of[i] = 1;
				m_of[i] = 1;
				ml_of[i] = 0;
			end
			clear_name();
		endfunction

		function void clear_name();
			acc_a = 0;
			acc_b = 0;
			foreach (name[i]) name[i] = 0;
			name_len = 0;
			overlong = 0;
		endfunction

		function int clamp(int v, int hi);
			if (v == 0) return 1;
			if (v > hi) return hi;
			return v;
		endfunction

		function out_t finish(int cls);
			out_t r;
			int u, v, idx, base;
			r.status = RES_MISS;
			r.slot_index = 0;
			if (cls >= NCLS) return r;
			if (overlong || name_len > ml_of[cls]) begin
				r.status = RES_LONG;
				return r;
			end
			u = acc_a % n_of[cls];
			v = acc_b % n_of[cls];
			idx = (int'(g_tab[cls*GSZ+u]) + int'(g_tab[cls*GSZ+v])) % m_of[cls];
			base = (cls*TSZ + idx) * ROW;
			for (int i = 0; i < name_len; i++)
				if (keys[base+i] != name[i]) return r;
			if (keys[base+name_len] != 0) return r;
			r.status = RES_FOUND;
			r.slot_index = idx[7:0];
			return r;
		endfunction

		function void note_input(in_t b);
			int cls, w;
			cls = b.class_id;
			case (b.req_type)
				REQ_WEIGHT: if (cls < NCLS && b.position < MAXL) begin
					wt_a[cls*MAXL+b.position] = b.weight_a;
					wt_b[cls*MAXL+b.position] = b.weight_b;
				end
				REQ_G: if (cls < NCLS && b.slot < GSZ) g_tab[cls*GSZ+b.slot] = b.g_value;
				REQ_KEY: if (cls < NCLS && b.slot < TSZ && b.position <= MAXL)
					keys[(cls*TSZ+b.slot)*ROW+b.position] = b.char_code;
				REQ_SIZES: if (cls < NCLS) begin
					n_of[cls] = clamp(b.size_n, GSZ);
					m_of[cls] = clamp(b.size_m, TSZ);
					ml_of[cls] = (b.max_len > MAXL) ? MAXL : b.max_len;
				end
				REQ_CHAR: if (b.char_code != 0) begin
					if (name_len >= MAXL) overlong = 1;
					else begin
						if (cls < NCLS) begin
							w = cls*MAXL + name_len;
							acc_a = acc_a + SUM_W'(wt_a[w] * b.char_code);
							acc_b = acc_b + SUM_W'(wt_b[w] * b.char_code);
						end
						name[name_len] = b.char_code;
						name_len++;
					end
				end else begin
					pending.push_back(finish(cls));
					clear_name();
				end
				default: ;
			endcase
		endfunction

		function void check_result(out_t got);
			out_t exp_r;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got.status !== exp_r.status || got.slot_index !== exp_r.slot_index) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
						exp_r.status, exp_r.slot_index, got.status, got.slot_index);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	in_t  in_data;
	out_t out_data;
	lookup_board sb;
	int   hold_off;
	bit   dict_ok [NCLS];
	logic [7:0] dict_key [NCLS][4][$];

	perfect_hash_key_lookup u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_input(in_data);
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	// Receiver stall pattern, with a long hold-off when requested.
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_ready <= 0;
				hold_off--;
			end else out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) && 0);
		end
	end

	task automatic send(in_t b);
		if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 8)) @(negedge clk);
		in_data <= b;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		in_valid <= 0;
	endtask

	function automatic in_t rand_beat();
		in_t b;
		b = {$urandom, $urandom, $urandom};
		return b;
	endfunction

	task automatic load_weight(int cls, int pos, int wa, int wb);
		in_t b;
		b = rand_beat();
		b.req_type = REQ_WEIGHT; b.class_id = cls; b.position = pos;
		b.weight_a = wa; b.weight_b = wb;
		send(b);
	endtask

	task automatic load_g(int cls, int s, int gv);
		in_t b;
		b = rand_beat();
		b.req_type = REQ_G; b.class_id = cls; b.slot = s; b.g_value = gv;
		send(b);
	endtask

	task automatic load_key(int cls, int s, int pos, int ch);
		in_t b;
		b = rand_beat();
		b.req_type = REQ_KEY; b.class_id = cls; b.slot = s; b.position = pos;
		b.char_code = ch;
		send(b);
	endtask

	task automatic load_sizes(int cls, int n, int m, int ml);
		in_t b;
		b = rand_beat();
		b.req_type = REQ_SIZES; b.class_id = cls; b.size_n = n; b.size_m = m;
		b.max_len = ml;
		send(b);
	endtask

	task automatic send_char(int cls, int ch);
		in_t b;
		b = rand_beat();
		b.req_type = REQ_CHAR; b.class_id = cls; b.char_code = ch;
		send(b);
	endtask

	// Initializes one class so that every later read is of written entries.
	task automatic setup_class(int cls, int n, int m, int ml);
		for (int p = 0; p < MAXL; p++)
			load_weight(cls, p, $urandom_range(0, 65535), $urandom_range(0, 65535));
		load_sizes(cls, n, m, ml);
		for (int s = 0; s < sb.n_of[cls]; s++) load_g(cls, s, $urandom_range(0, 255));
		for (int s = 0; s < sb.m_of[cls]; s++) load_key(cls, s, 0, 0);
		dict_ok[cls] = 1;
	endtask

	task automatic store_word(int cls, int s, int len);
		for (int p = 0; p < len; p++) load_key(cls, s, p, $urandom_range(1, 255));
		load_key(cls, s, len, 0);
	endtask

	task automatic lookup_slot(int cls, int s, int len);
		int base;
		base = (cls*TSZ + s) * ROW;
		for (int p = 0; p < len; p++) send_char(cls, sb.keys[base+p]);
		send_char(cls, 0);
	endtask

	task automatic random_name(int cls, int len);
		for (int p = 0; p < len; p++) send_char(cls, $urandom_range(1, 255));
		send_char(cls, 0);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	initial begin
		int cls, s, len, k, ok;
		sb = new();
		hold_off = 0;
		in_valid = 0;
		in_data = '0;
		arst_n = 0;
		repeat (12) @(negedge clk);
		arst_n = 1;

		setup_class(0, 4, 3, 5);
		setup_class(1, 1, 1, 0);
		store_word(1, 0, 0);
		store_word(0, 1, 3);
		store_word(0, 0, 5);
		store_word(0, 2, 2);
		// Directed: empty name, known words, overlong names, out-of-range items.
		send_char(1, 0);
		lookup_slot(0, 1, 3);
		lookup_slot(0, 0, 5);
		random_name(0, 6);
		random_name(0, MAXL + 2);
		random_name(0, 2);
		load_weight(0, 63, 65535, 65535);
		load_g(0, 255, 255);
		load_key(0, 255, 63, 255);
		begin
			in_t b;
			b = rand_beat(); b.req_type = 3'd7; send(b);
			b = rand_beat(); b.req_type = 3'd5; send(b);
		end
		drain();

		// Extreme sizes and the sender pause until idle.
		setup_class(2, 0, 0, 63);
		setup_class(3, 511, 511, 32);
		setup_class(4, 256, 256, 31);
		for (int c = 5; c < NCLS; c++)
			setup_class(c, $urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(0, 32));
		drain();

		k = 0;
		while (k < 400) begin
			cls = $urandom_range(0, NCLS-1);
			if (k == 150) begin
				hold_off = 300;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					s = $urandom_range(0, sb.m_of[cls]-1);
					len = $urandom_range(0, (sb.ml_of[cls] > 8) ? 8 : sb.ml_of[cls]);
					store_word(cls, s, len);
					lookup_slot(cls, s, len);
					k += 2*len + 2;
				end
				4, 5: begin
					random_name(cls, $urandom_range(0, 6));
					k += 3;
				end
				6: begin
					lookup_slot(cls, $urandom_range(0, sb.m_of[cls]-1), $urandom_range(0, 3));
					k += 2;
				end
				7: begin
					random_name(cls, (sb.ml_of[cls] < MAXL) ? sb.ml_of[cls] + 1 : MAXL + 1);
					k += 10;
				end
				8: begin
					load_weight(cls, $urandom_range(0, MAXL-1), $urandom, $urandom);
					load_g(cls, $urandom_range(0, sb.n_of[cls]-1), $urandom_range(0, 255));
					k += 2;
				end
				default: begin
					send_char(cls, $urandom_range(1, 255));
					send_char(cls, 0);
					k += 2;
				end
			endcase
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
